// ----- src/cascaded_biquad_iir_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter assertion macros
// Shared property forms for the filter checker; clk and rst come from scope.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_IIR_FILTER_MACROS_SVH
`define CASCADED_BIQUAD_IIR_FILTER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define CBQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbq check failed: same-cycle rule");

// Next-cycle implication, masked during reset.
`define CBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbq check failed: next-cycle rule");

`endif

// ----- src/cbq_pkg.sv -----
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter package
// Widths, register codes, sequencer states and saturation helpers.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int STAGES_DEF = 4;     // default number of sections
  localparam int SMP_W      = 24;    // sample width
  localparam int DAT_W      = 48;    // internal Q24 value width
  localparam int CFG_W      = 64;    // widest register
  localparam int IDX_W      = 3;     // register index width
  localparam int COEF_W     = 32;    // one Q2.30 coefficient
  localparam int DEN_REGS   = 4;     // sections with coefficient registers
  localparam int MASK_W     = 4;
  localparam int MANT_W     = 32;
  localparam int SHIFT_W    = 6;
  localparam int SHAMT_W    = 7;     // 7 + scale shift
  localparam int SCALE_PRE  = 7;     // fixed right shift after the scale multiply
  localparam int MA_W       = 33;    // multiplier operand a (signed)
  localparam int MB_W       = 25;    // multiplier operand b (signed)
  localparam int MUL_W      = MA_W + MB_W;
  localparam int HALF_W     = 24;    // split point of a 48-bit value
  localparam int BREG_W     = MUL_W - HALF_W;
  localparam int TSUM_W     = MUL_W + 1;
  localparam int QSH        = 6;     // 30 - 24
  localparam int ACC_W      = 54;    // section accumulator
  localparam int RND_W      = DAT_W + 1;

  localparam logic [MANT_W-1:0] MANT_RST = 32'h8000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_DEN0  = 3'd0,
    REG_DEN1  = 3'd1,
    REG_DEN2  = 3'd2,
    REG_DEN3  = 3'd3,
    REG_MASK  = 3'd4,
    REG_MANT  = 3'd5,
    REG_SHIFT = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RUN,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef logic signed [DAT_W-1:0] dat_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Out of signed 48-bit range
  function automatic logic ovf48(input acc_t v);
    logic [ACC_W-DAT_W:0] top;
    top = v[ACC_W-1:DAT_W-1];
    return !((&top) || (~|top));
  endfunction

  function automatic dat_t sat48(input acc_t v);
    dat_t r;
    if (ovf48(v)) begin
      r = v[ACC_W-1] ? {1'b1, {(DAT_W-1){1'b0}}} : {1'b0, {(DAT_W-1){1'b1}}};
    end else begin
      r = v[DAT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/cascaded_biquad_iir_filter.sv -----
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter
// Input scaling and STAGES direct-form-I sections on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / sample_in) takes one signed 24-bit
//   sample per item. in_ready is high only while the sequencer is idle.
//   Output channel (out_valid / out_ready / sample_out / clipped) gives one
//   filtered sample per item, rounded and saturated to 24 bits; clipped is set
//   when the scaled input, any section output or the final sample saturated.
//   Each item passes through the scale state, the run state (one section
//   after another), the finish state and the emit state before its result is
//   registered, and a new item is taken only once the last is through. The 33x25
//   multiplier makes one pass for the input scale and four passes per
//   section (low and high halves of y[n-2]*a2 and y[n-1]*a1).
//   A finished result sits in the output register while the next item is
//   taken; if out_ready stays low, the next item holds in its final state
//   until the register frees, and in_ready stays low meanwhile.
//   Reset clears the delay line, the coefficients and mask, sets the scale to
//   1.0 with no shift, and drops any pending result.
//   Configuration writes (cfg_we / cfg_index / cfg_data) are registered and
//   are meant for idle periods; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter
  import cbq_pkg::*;
#(
  parameter int STAGES = STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] sample_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] sample_out,
  output logic                    clipped,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int SC_W     = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int NEXT_IDX = (STAGES > 1) ? 1 : 0;
  localparam logic [SC_W-1:0] LAST_STAGE = SC_W'(STAGES - 1);

  // Configuration registers
  logic [CFG_W-1:0]   den [DEN_REGS];
  logic [MASK_W-1:0]  num_mask;
  logic [MANT_W-1:0]  mant;
  logic [SHIFT_W-1:0] shift;

  // Sequencer
  state_t          state, state_next;
  logic [SC_W-1:0] stage_cnt;
  logic [1:0]      step;

  // Datapath registers
  logic signed [SMP_W-1:0]  smp_reg;
  logic signed [MUL_W-1:0]  preg;
  logic signed [BREG_W-1:0] breg;
  acc_t                     acc;
  dat_t                     x;
  dat_t                     in1, in2;     // scaled input history
  dat_t                     pv1, pv2;     // history feeding the current section
  dat_t                     y1 [STAGES];  // section outputs, rotated so index 0 is current
  dat_t                     y2 [STAGES];
  logic                     clip_acc;

  // Combinational
  logic [3:0]               stage_ext;
  logic                     coef_ok;
  logic [CFG_W-1:0]         den_sel;
  logic                     mask_bit;
  logic signed [COEF_W-1:0] a1, a2;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MUL_W-1:0]  product;
  logic signed [TSUM_W-1:0] tsum;
  acc_t                     qv, acc_fin, scaled_acc, load_v, dbl, base;
  logic signed [MUL_W-1:0]  scaled;
  logic [SHAMT_W-1:0]       shamt;
  dat_t                     xval, y2_sel;
  logic                     xovf;
  logic                     load_x, from_scale, emit_go;
  logic signed [RND_W-1:0]  rsum;
  logic signed [SMP_W:0]    rnd;
  logic                     rnd_ovf;
  logic signed [SMP_W-1:0]  rnd_sat;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEN_REGS; i++) begin
        den[i] <= '0;
      end
      num_mask <= '0;
      mant     <= MANT_RST;
      shift    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEN0:  den[0]   <= cfg_data;
        REG_DEN1:  den[1]   <= cfg_data;
        REG_DEN2:  den[2]   <= cfg_data;
        REG_DEN3:  den[3]   <= cfg_data;
        REG_MASK:  num_mask <= cfg_data[MASK_W-1:0];
        REG_MANT:  mant     <= cfg_data[MANT_W-1:0];
        REG_SHIFT: shift    <= cfg_data[SHIFT_W-1:0];
        default:   ;  // drop writes beyond the list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Section coefficients; sections past the register list run with zero
  // feedback and weight -2 on x[n-1].
  // --------------------------------------------------------------------------
  always_comb begin
    stage_ext = 4'(stage_cnt);
    coef_ok   = stage_ext < 4'(DEN_REGS);
    den_sel   = coef_ok ? den[stage_ext[1:0]] : '0;
    mask_bit  = coef_ok & num_mask[stage_ext[1:0]];
    a1        = den_sel[CFG_W-1:COEF_W];
    a2        = den_sel[COEF_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Shared multiplier. Each 48x32 product goes through in two halves:
  // low 24 bits (unsigned) first, then the signed high 24 bits.
  // --------------------------------------------------------------------------
  always_comb begin
    y2_sel = (stage_cnt == '0) ? y2[0] : y2[NEXT_IDX];
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_SCALE: begin
        mul_a = MA_W'(signed'({1'b0, mant}));
        mul_b = MB_W'(smp_reg);
      end
      ST_RUN: begin
        case (step)
          2'd0: begin
            mul_a = MA_W'(a2);
            mul_b = signed'({1'b0, y2_sel[HALF_W-1:0]});
          end
          2'd1: begin
            mul_a = MA_W'(a2);
            mul_b = {y2[0][DAT_W-1], y2[0][DAT_W-1:HALF_W]};
          end
          2'd2: begin
            mul_a = MA_W'(a1);
            mul_b = signed'({1'b0, y1[0][HALF_W-1:0]});
          end
          2'd3: begin
            mul_a = MA_W'(a1);
            mul_b = {y1[0][DAT_W-1], y1[0][DAT_W-1:HALF_W]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign product = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Arithmetic around the product register
  // --------------------------------------------------------------------------
  always_comb begin
    // floor(y*c / 2^30) = floor((hi + floor(lo / 2^24)) / 2^6)
    tsum       = TSUM_W'(preg) + TSUM_W'(breg);
    qv         = ACC_W'(tsum >>> QSH);
    acc_fin    = acc - qv;
    shamt      = SHAMT_W'(shift) + SHAMT_W'(SCALE_PRE);
    scaled     = preg >>> shamt;
    scaled_acc = ACC_W'(scaled);
    from_scale = (state == ST_RUN) && (stage_cnt == '0);
    load_v     = from_scale ? scaled_acc : acc_fin;
    xval       = sat48(load_v);
    xovf       = ovf48(load_v);
    dbl        = ACC_W'(pv1) <<< 1;
    base       = ACC_W'(x) + ACC_W'(pv2) + (mask_bit ? dbl : -dbl);
    // Round half up to an integer sample, then clamp to 24 bits
    rsum       = RND_W'(x) + RND_W'(1 << (HALF_W - 1));
    rnd        = rsum[RND_W-1:HALF_W];
    rnd_ovf    = rnd[SMP_W] != rnd[SMP_W-1];
    if (rnd_ovf) begin
      rnd_sat = rnd[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      rnd_sat = rnd[SMP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_RUN;
      ST_RUN:   if (step == 2'd3 && stage_cnt == LAST_STAGE) state_next = ST_FIN;
      ST_FIN:   state_next = ST_EMIT;
      ST_EMIT:  if (emit_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    load_x   = ((state == ST_RUN) && (step == 2'd0)) || (state == ST_FIN);
    emit_go  = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stage_cnt <= '0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          stage_cnt <= (stage_cnt == LAST_STAGE) ? '0 : stage_cnt + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    preg <= product;
    if (in_valid && in_ready) begin
      smp_reg <= sample_in;
    end
    if (state == ST_RUN && (step == 2'd1 || step == 2'd3)) begin
      breg <= BREG_W'(preg >>> HALF_W);
    end
    if (state == ST_RUN && step == 2'd1) begin
      acc <= base;
    end else if (state == ST_RUN && step == 2'd2) begin
      acc <= acc_fin;
    end
  end

  // Delay line and section value: reset to zero, advance once per section
  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= '0;
      in1      <= '0;
      in2      <= '0;
      pv1      <= '0;
      pv2      <= '0;
      clip_acc <= 1'b0;
      for (int i = 0; i < STAGES; i++) begin
        y1[i] <= '0;
        y2[i] <= '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        clip_acc <= 1'b0;
      end else if (load_x) begin
        x        <= xval;
        clip_acc <= clip_acc | xovf;
        if (from_scale) begin
          // first section reads the old input history; push the new input
          pv1 <= in1;
          pv2 <= in2;
          in1 <= xval;
          in2 <= in1;
        end else begin
          // close the finished section: hand its old history to the next one
          // and rotate the delay line so the next section sits at index 0
          pv1 <= y1[0];
          pv2 <= y2[0];
          for (int i = 0; i < STAGES - 1; i++) begin
            y1[i] <= y1[i+1];
            y2[i] <= y2[i+1];
          end
          y1[STAGES-1] <= xval;
          y2[STAGES-1] <= y1[0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      sample_out <= rnd_sat;
      clipped    <= clip_acc | rnd_ovf;
    end
  end

endmodule

// ----- src/cbq_checker.sv -----
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter checker
// Port-level checks on the filter's handshakes, bound into the filter module.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_iir_filter_macros.svh"

module cbq_checker
  import cbq_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SMP_W-1:0] sample_out,
  input logic                    clipped
);

  // A stalled result holds
  `CBQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(sample_out) && $stable(clipped))

  // One item at a time: busy right after an accept
  `CBQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A result never shows up right after its item is taken
  `CBQ_ASSERT_NOW(a_no_early_result, $rose(out_valid), !$past(in_valid && in_ready))

  // Nothing pending once reset is released
  `CBQ_ASSERT_NOW(a_clean_after_reset, $past(rst), !out_valid && in_ready)

endmodule

bind cascaded_biquad_iir_filter cbq_checker u_cbq_checker (.*);

// ----- bench/cascaded_biquad_iir_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter testbench
// Feeds signed samples through the valid/ready input channel and compares
// every filtered sample and clip flag with a bit-exact fixed-point predictor.
// Coefficients, mask and input scale change between phases while the filter
// is idle. Both channels idle at random, and one long output hold-off backs
// the filter up into its input.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter_tb;
  import cbq_pkg::*;

  // Number of sections in the instance; all of them have registers here
  localparam int N_SECT = STAGES_DEF;

  localparam int CYCLE_LIMIT = 250_000;
  localparam int LONG_HOLD   = 400;    // output hold-off, in cycles
  localparam int DRAIN_WAIT  = 40;     // covers the filter's result latency
  localparam int MAX_LINES   = 50;

  // Index beyond the register list; the filter drops such writes
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  localparam longint Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q48_MIN = -Q48_MAX - 64'sd1;

  // Resonant low-frequency section and its overall gain
  localparam real A1_REAL   = -1.9982320133163622;
  localparam real A2_REAL   = 0.9983439863360103;
  localparam real GAIN_REAL = 19470457182.946293;
  localparam real Q30_ONE   = 1073741824.0;
  localparam real TWO_P65   = 36893488147419103232.0;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    clip;
  } filt_res_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] sample_out;
  logic                    clipped;
  logic                    cfg_we    = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data  = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  cascaded_biquad_iir_filter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the shared delay line
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]   den_coef [DEN_REGS];
  logic [MASK_W-1:0]  num_mask   = '0;
  logic [MANT_W-1:0]  scale_mant = MANT_RST;
  logic [SHIFT_W-1:0] scale_sh   = '0;
  longint             x_hist [2];          // scaled x[n-1], x[n-2]
  longint             y_hist [2*N_SECT];   // per section: y[n-1], y[n-2]

  initial begin
    foreach (den_coef[i]) den_coef[i] = '0;
    foreach (x_hist[i]) x_hist[i] = 0;
    foreach (y_hist[i]) y_hist[i] = 0;
  end

  // Bookkeeping between stimulus, driver and checker
  logic signed [SMP_W-1:0] pending_q [$];
  filt_res_t               filtered_q [$];
  int  queued_cnt  = 0;
  int  accept_cnt  = 0;
  int  acked_cnt   = 0;
  int  result_cnt  = 0;
  int  taken_res   = 0;
  int  gap_left    = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  int  err_cnt     = 0;
  int  cycle_cnt   = 0;
  bit  no_idle     = 1'b0;
  bit  long_hold   = 1'b0;

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------

  // Clamp to the signed 48-bit range, flag when it bites
  function automatic longint clamp48(input longint v, inout bit flag);
    if (v > Q48_MAX) begin
      flag = 1'b1;
      return Q48_MAX;
    end
    if (v < Q48_MIN) begin
      flag = 1'b1;
      return Q48_MIN;
    end
    return v;
  endfunction

  // Q24 value times Q2.30 coefficient, floored back to Q24
  function automatic longint coef_mul(input longint y, input logic signed [COEF_W-1:0] c);
    logic signed [95:0] wy;
    logic signed [95:0] wc;
    logic signed [95:0] prod;
    wy   = 96'(y);
    wc   = 96'(c);
    prod = wy * wc;
    return longint'(prod >>> 30);
  endfunction

  // Run one sample through scaling and all sections, advance the delay line
  function automatic filt_res_t filter_sample(input logic signed [SMP_W-1:0] smp);
    filt_res_t                res;
    longint                   sect_out [N_SECT];
    longint                   x0;
    longint                   x;
    longint                   xm1;
    longint                   xm2;
    longint                   acc;
    longint                   rnd;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    int                       sh;
    bit                       clip;
    clip = 1'b0;
    sh   = SCALE_PRE + int'(scale_sh);
    if (sh > 63) sh = 63;
    x0 = clamp48((longint'(smp) * longint'(scale_mant)) >>> sh, clip);
    x  = x0;
    for (int s = 0; s < N_SECT; s++) begin
      xm1 = (s == 0) ? x_hist[0] : y_hist[2*s-2];
      xm2 = (s == 0) ? x_hist[1] : y_hist[2*s-1];
      a1  = den_coef[s][63:32];
      a2  = den_coef[s][31:0];
      acc = x + xm2;
      if (num_mask[s]) acc = acc + 2 * xm1;
      else acc = acc - 2 * xm1;
      acc = acc - coef_mul(y_hist[2*s+1], a2);
      acc = acc - coef_mul(y_hist[2*s], a1);
      x   = clamp48(acc, clip);
      sect_out[s] = x;
    end
    x_hist[1] = x_hist[0];
    x_hist[0] = x0;
    for (int s = 0; s < N_SECT; s++) begin
      y_hist[2*s+1] = y_hist[2*s];
      y_hist[2*s]   = sect_out[s];
    end
    // Round half up to an integer sample, then saturate to 24 bits
    rnd = (x + 64'sd8388608) >>> 24;
    if (rnd > 64'sd8388607) begin
      rnd  = 64'sd8388607;
      clip = 1'b1;
    end else if (rnd < -64'sd8388608) begin
      rnd  = -64'sd8388608;
      clip = 1'b1;
    end
    res.smp  = rnd[SMP_W-1:0];
    res.clip = clip;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    // Keep the log readable when a bug hits every item
    if (err_cnt <= MAX_LINES) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register at a falling edge and mirror it in the predictor
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DEN0, REG_DEN1, REG_DEN2, REG_DEN3: den_coef[idx[1:0]] = data;
      REG_MASK:  num_mask   = data[MASK_W-1:0];
      REG_MANT:  scale_mant = data[MANT_W-1:0];
      REG_SHIFT: scale_sh   = data[SHIFT_W-1:0];
      default: ;  // beyond the list: nothing changes
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [SMP_W-1:0] v);
    pending_q.push_back(v);
    queued_cnt++;
  endtask

  // Mostly full-range samples, with extremes and small values mixed in
  function automatic logic signed [SMP_W-1:0] pick_sample();
    logic signed [SMP_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 24'h7F_FFFF;
      1:       v = 24'h80_0000;
      2, 3:    v = 24'($urandom_range(0, 511)) - 24'd256;
      default: v = 24'($urandom());
    endcase
    return v;
  endfunction

  task automatic push_random(input int n);
    // Start on a rising edge so the driver sees the items at a clean falling edge
    @(posedge clk);
    repeat (n) push_sample(pick_sample());
  endtask

  // Hold the sender until every queued item is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (accept_cnt != queued_cnt || filtered_q.size() != 0);
  endtask

  function automatic logic [CFG_W-1:0] rand_den();
    return {$urandom(), $urandom()};
  endfunction

  // Coefficients within +-0.25 keep the sections tame
  function automatic logic [CFG_W-1:0] tame_den();
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    a1 = 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
    a2 = 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
    return {a1, a2};
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: present pending items at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : feed_samples
    logic                    nxt_valid;
    logic signed [SMP_W-1:0] nxt_smp;
    nxt_valid = in_valid;
    nxt_smp   = sample_in;
    if (!rst) begin
      // Drop the item the filter took at the last rising edge
      if (accept_cnt != acked_cnt) begin
        acked_cnt = accept_cnt;
        nxt_valid = 1'b0;
      end
      // Wait out this item's gap, then offer the next one
      if (!nxt_valid && pending_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt_smp   = pending_q.pop_front();
          nxt_valid = 1'b1;
          gap_left  = no_idle ? 0 : $urandom_range(0, 11);
        end
      end
    end
    // One assignment per edge: valid stays high straight into the next item
    in_valid  <= nxt_valid;
    sample_in <= nxt_smp;
  end

  // Predict at the rising edge that accepts an item
  always @(posedge clk) begin : predict_on_accept
    if (!rst && in_valid && in_ready) begin
      filtered_q.push_back(filter_sample(sample_in));
      accept_cnt++;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : pace_results
    if (!rst) begin
      if (long_hold) begin
        hold_left = LONG_HOLD;
        long_hold = 1'b0;
      end
      // Draw a fresh stall after each result taken
      if (result_cnt != taken_res) begin
        taken_res  = result_cnt;
        stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    filt_res_t want;
    if (!rst && out_valid && out_ready) begin
      result_cnt++;
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item sample_out=%0d clipped=%0b",
                                  sample_out, clipped));
      end else begin
        want = filtered_q.pop_front();
        if (sample_out !== want.smp)
          report_mismatch($sformatf("item %0d sample_out=%0d want %0d",
                                    result_cnt, sample_out, want.smp));
        if (clipped !== want.clip)
          report_mismatch($sformatf("item %0d clipped=%0b want %0b",
                                    result_cnt, clipped, want.clip));
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycle_cnt, filtered_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    logic [COEF_W-1:0] a1_q;
    logic [COEF_W-1:0] a2_q;
    logic [MANT_W-1:0] gain_mant;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: pure (1 - z^-1)^2 sections at unit scale.
    // Hit both sample extremes and every bit in both states.
    push_sample(24'sd0);
    push_sample(24'h7F_FFFF);
    push_sample(24'h80_0000);
    push_sample(-24'sd1);
    push_sample(24'sd1);
    push_sample(24'h55_5555);
    push_sample(24'hAA_AAAA);
    push_sample(24'sd0);
    wait_idle();

    // A write past the register list must change nothing; the mask
    // keeps only its low bits. Full-scale mantissa overflows the scaled input.
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MASK, 64'hFFFF_FFFF_FFFF_FFF5);
    write_reg(REG_MANT, 64'h0000_0000_FFFF_FFFF);
    push_sample(24'h80_0000);
    push_sample(24'h7F_FFFF);
    push_sample(24'h80_0000);
    push_sample(24'sd0);
    wait_idle();

    // Largest shift: the scale collapses to 0 or -1
    write_reg(REG_SHIFT, 64'd63);
    push_sample(24'h80_0000);
    push_sample(24'sd5);
    push_sample(24'h7F_FFFF);
    wait_idle();

    // Coefficient extremes: -2.0, just under +2.0, tiny negatives, and +-1.0
    write_reg(REG_SHIFT, 64'd0);
    write_reg(REG_MANT, {32'd0, MANT_RST});
    write_reg(REG_DEN0, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_DEN1, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_DEN2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_DEN3, 64'h4000_0000_C000_0000);
    push_sample(24'h7F_FFFF);
    push_sample(24'h80_0000);
    push_sample(24'sd1);
    push_sample(24'sd0);
    push_sample(24'sd0);
    push_sample(24'sd0);
    wait_idle();

    // Phase 1: realistic resonant sections, scale set from the gain.
    // Hold the output off for a long stretch while items keep coming.
    a1_q      = $rtoi(A1_REAL * Q30_ONE);
    a2_q      = $rtoi(A2_REAL * Q30_ONE);
    gain_mant = $rtoi(TWO_P65 / GAIN_REAL);
    for (int s = 0; s < DEN_REGS; s++) write_reg(IDX_W'(REG_DEN0 + s), {a1_q, a2_q});
    write_reg(REG_MASK, 64'd0);
    write_reg(REG_MANT, {32'd0, gain_mant});
    write_reg(REG_SHIFT, 64'd34);
    push_random(160);
    @(posedge clk);
    long_hold = 1'b1;
    wait_idle();

    // Phase 2: low-pass numerators, larger scale, back-to-back traffic
    no_idle = 1'b1;
    write_reg(REG_MASK, 64'd15);
    write_reg(REG_MANT, {32'd0, $urandom()});
    write_reg(REG_SHIFT, 64'($urandom_range(8, 20)));
    push_random(150);
    wait_idle();
    no_idle = 1'b0;

    // Phase 3: anything goes, saturation everywhere
    for (int s = 0; s < DEN_REGS; s++) write_reg(IDX_W'(REG_DEN0 + s), rand_den());
    write_reg(REG_MASK, 64'($urandom_range(0, 15)));
    write_reg(REG_MANT, {32'd0, $urandom()});
    write_reg(REG_SHIFT, 64'($urandom_range(0, 63)));
    push_random(130);
    wait_idle();

    // Phase 4: small coefficients, moderate scale
    for (int s = 0; s < DEN_REGS; s++) write_reg(IDX_W'(REG_DEN0 + s), tame_den());
    write_reg(REG_MASK, 64'($urandom_range(0, 15)));
    write_reg(REG_MANT, {32'd0, $urandom()});
    write_reg(REG_SHIFT, 64'($urandom_range(0, 20)));
    push_random(130);
    wait_idle();

    // Phase 5: zero mantissa flushes the input; only history decays out
    for (int s = 0; s < DEN_REGS; s++) write_reg(IDX_W'(REG_DEN0 + s), 64'd0);
    write_reg(REG_MASK, 64'($urandom_range(0, 15)));
    write_reg(REG_MANT, 64'd0);
    push_random(60);
    wait_idle();

    // Let any stray result show up before judging
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/cbq_pkg.sv
src/cascaded_biquad_iir_filter.sv
src/cbq_checker.sv
bench/cascaded_biquad_iir_filter_tb.sv
